@@ rtl/fsqrt_pkg.sv @@
package fsqrt_pkg;

    localparam int unsigned NUM_STEPS = 25;
    localparam int unsigned REM_W     = 28;

    localparam logic [31:0] QNAN_CANON = 32'h7fc0_0000;
    localparam logic [31:0] PLUS_INF   = 32'h7f80_0000;
    localparam logic [31:0] HALF_BIAS  = 32'h3f00_0000;
    localparam logic [9:0]  EXP_BIAS   = 10'd127;

    localparam logic [1:0] CLS_NUM  = 2'd0;
    localparam logic [1:0] CLS_ZERO = 2'd1;
    localparam logic [1:0] CLS_INF  = 2'd2;
    localparam logic [1:0] CLS_NAN  = 2'd3;

    localparam logic [1:0] RM_NEAR = 2'd0;
    localparam logic [1:0] RM_ZERO = 2'd1;
    localparam logic [1:0] RM_DOWN = 2'd2;
    localparam logic [1:0] RM_UP   = 2'd3;

    // Position of the highest set bit of a subnormal fraction, counted from bit 22.
    function automatic logic [4:0] lzc23(input logic [22:0] frac);
        logic [4:0] cnt;
        cnt = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) begin
                cnt = 5'(22 - i);
            end
        end
        return cnt;
    endfunction

endpackage

@@ rtl/float32_square_root.sv @@
// Pipelined IEEE-754 single-precision square root. A request is taken in every cycle
// (busy is always low). Its result is on o_root, o_inexact and o_invalid for exactly
// one cycle, marked by o_valid, once the request has passed every register stage. The
// 28 register stages are one input stage, one normalization stage, 25 stages of the
// restoring root (one result bit each) and one rounding stage. The receiver cannot
// stall the pipeline. The rounding mode is applied in the last stage, so it must be
// changed only while no request is in flight.
module float32_square_root
    import fsqrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_operand,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_root,
    output logic        o_inexact,
    output logic        o_invalid
);

    logic [1:0]  r_round_mode;

    logic        r_in_vld;
    logic [31:0] r_in_op;

    logic                    r_vld  [0:NUM_STEPS];
    logic [1:0]              r_cls  [0:NUM_STEPS];
    logic                    r_sgn  [0:NUM_STEPS];
    logic signed [7:0]       r_half [0:NUM_STEPS];
    logic [REM_W-1:0]        r_ix   [0:NUM_STEPS];
    logic [REM_W-1:0]        r_s    [0:NUM_STEPS];
    logic [NUM_STEPS-1:0]    r_q    [0:NUM_STEPS];

    logic [7:0]        ef;
    logic [22:0]       frac;
    logic [4:0]        lz;
    logic [23:0]       mant;
    logic signed [9:0] m_exp;
    logic [1:0]        n_cls;
    logic [REM_W-1:0]  n_ix0;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_mode <= RM_NEAR;
            r_in_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_round_mode <= i_cfg_data;
            end
            r_in_vld <= start;
        end
        r_in_op <= i_operand;
    end

    // Classification and normalization of subnormals.
    always_comb begin
        ef   = r_in_op[30:23];
        frac = r_in_op[22:0];
        lz   = lzc23(frac);
        if (ef == 8'hff) begin
            n_cls = (!r_in_op[31] && frac == 23'd0) ? CLS_INF : CLS_NAN;
        end else if (ef == 8'd0 && frac == 23'd0) begin
            n_cls = CLS_ZERO;
        end else if (r_in_op[31]) begin
            n_cls = CLS_NAN;
        end else begin
            n_cls = CLS_NUM;
        end
        if (ef == 8'd0) begin
            mant  = {1'b0, frac} << (lz + 5'd1);
            m_exp = -10'sd126 - $signed({5'd0, lz}) - 10'sd1;
        end else begin
            mant  = {1'b1, frac};
            m_exp = $signed({2'd0, ef}) - $signed(EXP_BIAS);
        end
        mant[23] = 1'b1;
        if (m_exp[0]) begin
            n_ix0 = {2'd0, mant, 2'd0};
        end else begin
            n_ix0 = {3'd0, mant, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_in_vld;
        end
        r_cls[0]  <= n_cls;
        r_sgn[0]  <= r_in_op[31];
        r_half[0] <= 8'(m_exp >>> 1);
        r_ix[0]   <= n_ix0;
        r_s[0]    <= '0;
        r_q[0]    <= '0;
    end

    for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
        localparam logic [REM_W-1:0] STEP_BIT = REM_W'(1) << (NUM_STEPS - 1 - j);
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] n_ix;
        logic [REM_W-1:0] n_s;
        logic [NUM_STEPS-1:0] n_q;

        always_comb begin
            t = r_s[j] + STEP_BIT;
            if (t <= r_ix[j]) begin
                n_s  = t + STEP_BIT;
                n_ix = (r_ix[j] - t) << 1;
                n_q  = r_q[j] | STEP_BIT[NUM_STEPS-1:0];
            end else begin
                n_s  = r_s[j];
                n_ix = r_ix[j] << 1;
                n_q  = r_q[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
            r_cls[j+1]  <= r_cls[j];
            r_sgn[j+1]  <= r_sgn[j];
            r_half[j+1] <= r_half[j];
            r_ix[j+1]   <= n_ix;
            r_s[j+1]    <= n_s;
            r_q[j+1]    <= n_q;
        end
    end

    logic              rem_nz;
    logic [25:0]       q_rnd;
    logic [31:0]       n_root;
    logic              n_inexact;
    logic              n_invalid;

    always_comb begin
        rem_nz = (r_ix[NUM_STEPS] != '0);
        q_rnd  = {1'b0, r_q[NUM_STEPS]};
        if (rem_nz) begin
            case (r_round_mode)
                RM_UP:   q_rnd = q_rnd + 26'd2;
                RM_NEAR: q_rnd = q_rnd + {25'd0, q_rnd[0]};
                default: q_rnd = q_rnd;
            endcase
        end
        n_inexact = 1'b0;
        n_invalid = 1'b0;
        unique case (r_cls[NUM_STEPS])
            CLS_ZERO: n_root = {r_sgn[NUM_STEPS], 31'd0};
            CLS_INF:  n_root = PLUS_INF;
            CLS_NAN: begin
                n_root    = QNAN_CANON;
                n_invalid = 1'b1;
            end
            default: begin
                n_root = {7'd0, q_rnd[25:1]} + HALF_BIAS
                       + ({{24{r_half[NUM_STEPS][7]}}, r_half[NUM_STEPS]} << 23);
                n_inexact = rem_nz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[NUM_STEPS];
        end
        o_root    <= n_root;
        o_inexact <= n_inexact;
        o_invalid <= n_invalid;
    end

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(start, 28) && $past(i_rst_n, 28) && $past(i_rst_n, 1) |-> o_valid)
        else $error("request did not complete after 28 cycles");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_inexact && o_invalid))
        else $error("inexact and invalid raised together");

    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_root == QNAN_CANON)
        else $error("invalid result is not the canonical NaN");

    a_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_STEPS] |=> o_valid)
        else $error("result lost in the rounding stage");
`endif

endmodule

@@ tb/sv/tb_float32_square_root.sv @@
module tb_float32_square_root;
    import fsqrt_pkg::*;

    localparam int LATENCY     = 28;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_operand;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_data;
    logic        o_valid;
    logic [31:0] o_root;
    logic        o_inexact;
    logic        o_invalid;

    typedef struct packed {
        logic [31:0] root;
        logic        inexact;
        logic        invalid;
    } t_sqrt_result;

    typedef struct {
        logic [31:0] operand;
        int          gap;
    } t_sqrt_request;

    t_sqrt_request pending_q[$];
    t_sqrt_result  expected_q[$];
    logic [1:0]    round_sel;
    int            error_count;
    int            idle_cycles;
    int            gap_left;
    bit            accepted_last;

    float32_square_root dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operand  (i_operand),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_root     (o_root),
        .o_inexact  (o_inexact),
        .o_invalid  (o_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_sqrt_result compute_sqrt(input logic [31:0] x, input logic [1:0] rm);
        t_sqrt_result res;
        logic [7:0]  ef;
        logic [22:0] frac;
        logic [31:0] ix, s, q, r, t;
        int          m, k, half, i;
        ef   = x[30:23];
        frac = x[22:0];
        res  = '0;
        if (ef == 8'hff) begin
            if (!x[31] && frac == 0) res.root = x;
            else begin
                res.root    = QNAN_CANON;
                res.invalid = 1'b1;
            end
            return res;
        end
        if (ef == 0 && frac == 0) begin
            res.root = x;
            return res;
        end
        if (x[31]) begin
            res.root    = QNAN_CANON;
            res.invalid = 1'b1;
            return res;
        end
        ix = x;
        m  = ef;
        if (m == 0) begin
            i = 0;
            while (!ix[23] && i < 24) begin
                ix = ix << 1;
                i++;
            end
            m = 1 - i;
        end
        m  = m - 127;
        ix = {9'd0, ix[22:0]} | 32'h0080_0000;
        k  = m + 256;
        if (k[0]) ix = ix << 1;
        half = (k >>> 1) - 128;
        ix = ix << 1;
        q  = 0;
        s  = 0;
        r  = 32'h0100_0000;
        while (r != 0) begin
            t = s + r;
            if (t <= ix) begin
                s  = t + r;
                ix = ix - t;
                q  = q + r;
            end
            ix = ix << 1;
            r  = r >> 1;
        end
        if (ix != 0) begin
            res.inexact = 1'b1;
            if (rm == RM_UP) q = q + 2;
            else if (rm == RM_NEAR) q = q + {31'd0, q[0]};
        end
        res.root = (q >> 1) + HALF_BIAS + (32'(half) << 23);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic queue_request(input logic [31:0] op, input bit gappy);
        t_sqrt_request req;
        req.operand = op;
        req.gap     = gappy ? $urandom_range(0, 7) : 0;
        pending_q.push_back(req);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hff;
            2: v[30:0]  = 31'd0;
            3, 4: v[31] = 1'b1;
            default: v[31] = 1'b0;
        endcase
        return v;
    endfunction

    // Every accepted request gets its expected result queued.
    always @(posedge i_clk) begin
        accepted_last <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            expected_q.push_back(compute_sqrt(i_operand, round_sel));
        end
    end

    // Driver: one request per accepted cycle, with a random gap before each one queued as gappy.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !accepted_last) begin
                // still waiting on the handshake; keep the request up
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_q.size() > 0) begin
                if (pending_q[0].gap > 0) begin
                    start    <= 1'b0;
                    gap_left <= pending_q[0].gap - 1;
                    pending_q[0].gap = 0;
                end else begin
                    i_operand <= pending_q[0].operand;
                    start     <= 1'b1;
                    void'(pending_q.pop_front());
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_sqrt_result want;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", o_root, 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_root !== want.root) report_mismatch("root", o_root, want.root);
                    if (o_inexact !== want.inexact)
                        report_mismatch("inexact", {31'd0, o_inexact}, {31'd0, want.inexact});
                    if (o_invalid !== want.invalid)
                        report_mismatch("invalid", {31'd0, o_invalid}, {31'd0, want.invalid});
                end
            end
            if (idle_cycles > STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_round(input logic [1:0] rm);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= rm;
        round_sel  = rm;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [1:0] modes[5];
        start       = 1'b0;
        i_operand   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        round_sel   = RM_NEAR;
        error_count = 0;
        idle_cycles = 0;
        gap_left    = 0;
        modes = '{RM_NEAR, RM_ZERO, RM_DOWN, RM_UP, RM_NEAR};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zeros, infinities, NaNs, negatives, subnormal and normal extremes.
        foreach (modes[mi]) begin
            set_round(modes[mi]);
            queue_request(32'h0000_0000, 0);
            queue_request(32'h8000_0000, 0);
            queue_request(32'h7f80_0000, 0);
            queue_request(32'hff80_0000, 0);
            queue_request(32'h7fc0_0000, 0);
            queue_request(32'h7f80_0001, 0);
            queue_request(32'hffff_ffff, 0);
            queue_request(32'h8000_0001, 0);
            queue_request(32'h0000_0001, 1);
            queue_request(32'h007f_ffff, 0);
            queue_request(32'h0080_0000, 0);
            queue_request(32'h7f7f_ffff, 1);
            queue_request(32'h3f80_0000, 0);
            queue_request(32'h4000_0000, 0);
            queue_request(32'h4080_0000, 0);
            queue_request(32'h3fff_ffff, 0);
            queue_request(32'h0000_0002, 1);
            queue_request(32'h0040_0000, 0);
            for (int n = 0; n < 360; n++) queue_request(random_operand(), $urandom_range(0, 3) != 0);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
